FILE: rtl/core/assert_macros.svh
// Assertion helpers for the RTL files; the encoder includes them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every rising clock edge outside reset.
`define WZS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("assertion %m failed");

// The condition must never be true outside reset.
`define WZS_NEVER(lbl, clk, rst_n, cond) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("assertion %m failed");

`endif

FILE: rtl/core/wzs_pkg.sv
package wzs_pkg;

	localparam int SAMPLE_W     = 16;
	localparam int OFFSET_W     = 12;
	localparam int WCOUNT_W     = 13;
	localparam int RUN_W        = 14;
	localparam int CFG_W        = 16;

	localparam int MAX_SAMPLES_DEF = 4096;
	localparam int MAX_RES         = 3;
	localparam int RES_DEPTH_DEF   = 4;

	localparam logic [CFG_W-1:0]    LOW_RESET  = 16'h0041;
	localparam logic [CFG_W-1:0]    HIGH_RESET = 16'h03bf;
	localparam logic [SAMPLE_W-1:0] SKIP_FLAG  = 16'h8000;
	localparam logic [WCOUNT_W-1:0] WORDS_MAX  = 13'h1fff;

	typedef enum logic [1:0] {
		KIND_SAMPLE  = 2'd0,
		KIND_SKIP    = 2'd1,
		KIND_SUMMARY = 2'd2
	} kind_t;

	typedef enum logic {
		CFG_LOW  = 1'b0,
		CFG_HIGH = 1'b1
	} cfg_idx_t;

	typedef struct packed {
		kind_t                kind;
		logic [SAMPLE_W-1:0]  word;
		logic [OFFSET_W-1:0]  first_offset;
		logic                 found;
		logic [WCOUNT_W-1:0]  word_count;
		logic                 run_end;
	} res_t;

	function automatic logic [WCOUNT_W-1:0] words_inc(input logic [WCOUNT_W-1:0] w);
		return (w == WORDS_MAX) ? w : w + WCOUNT_W'(1);
	endfunction

endpackage

FILE: rtl/core/wzs_if.sv
interface wzs_in_if;
	logic        valid;
	logic        ready;
	logic [15:0] sample;
	logic        first_sample;
	logic        last_sample;

	modport source (output valid, output sample, output first_sample, output last_sample,
		input ready);
	modport sink (input valid, input sample, input first_sample, input last_sample,
		output ready);
endinterface

interface wzs_out_if;
	logic        valid;
	logic        ready;
	logic [1:0]  kind;
	logic [15:0] word;
	logic [11:0] first_offset;
	logic        found;
	logic [12:0] word_count;
	logic        run_end;

	modport source (output valid, output kind, output word, output first_offset,
		output found, output word_count, output run_end, input ready);
	modport sink (input valid, input kind, input word, input first_offset,
		input found, input word_count, input run_end, output ready);
endinterface

FILE: rtl/core/wzs_res_fifo.sv
module wzs_res_fifo import wzs_pkg::*; #(
	parameter int DEPTH    = RES_DEPTH_DEF,
	parameter int PUSH_MAX = MAX_RES
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic [$clog2(PUSH_MAX+1)-1:0]   push_n,
	input  res_t                            push_data [PUSH_MAX],
	output logic                            room,
	wzs_out_if.source                       out_ch
);

	// DEPTH is a power of two so that the pointers wrap on their own.
	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	res_t             mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;
	logic             pop;

	assign pop  = out_ch.valid && out_ch.ready;
	// A whole item's results must fit without counting this cycle's pop.
	assign room = count_q <= CNT_W'(DEPTH - PUSH_MAX);

	always_ff @(posedge clk) begin
		for (int i = 0; i < PUSH_MAX; i++) begin
			if (i < int'(push_n)) begin
				mem_q[PTR_W'(wr_q + PTR_W'(i))] <= push_data[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			wr_q    <= PTR_W'(wr_q + PTR_W'(push_n));
			rd_q    <= PTR_W'(rd_q + PTR_W'(pop));
			count_q <= CNT_W'(count_q + CNT_W'(push_n) - CNT_W'(pop));
		end
	end

	assign out_ch.valid        = count_q != '0;
	assign out_ch.kind         = mem_q[rd_q].kind;
	assign out_ch.word         = mem_q[rd_q].word;
	assign out_ch.first_offset = mem_q[rd_q].first_offset;
	assign out_ch.found        = mem_q[rd_q].found;
	assign out_ch.word_count   = mem_q[rd_q].word_count;
	assign out_ch.run_end      = mem_q[rd_q].run_end;

endmodule

FILE: rtl/core/window_zero_suppress_skip_encoder.sv
// Windowed zero-suppression encoder: samples outside [low_threshold, high_threshold] are
// passed on, in-window runs after the first kept sample become skip tokens (bit 15 set,
// run length minus one in the low 14 bits) placed just before the next kept sample, and
// the last sample of an event is followed by a summary result. An item is taken every
// clock as long as each item yields at most one result and out_ch.ready stays high; an
// item that yields two or three results holds the input until the result queue has room,
// since the output moves one result per clock, while out_ch.ready is high, out of a
// four-entry result queue. A result passes through the input register and then the result
// queue. Thresholds may be written only while the block is idle.
`include "assert_macros.svh"

module window_zero_suppress_skip_encoder import wzs_pkg::*; #(
	parameter int MAX_SAMPLES = MAX_SAMPLES_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	wzs_in_if.sink           in_ch,
	wzs_out_if.source        out_ch,
	input  logic             cfg_we,
	input  logic             cfg_index,
	input  logic [CFG_W-1:0] cfg_data
);

	localparam int IDX_W = $clog2(MAX_SAMPLES);
	localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(MAX_SAMPLES - 1);

	// Thresholds
	logic [CFG_W-1:0] low_q;
	logic [CFG_W-1:0] high_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			low_q  <= LOW_RESET;
			high_q <= HIGH_RESET;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_LOW:  low_q  <= cfg_data;
				CFG_HIGH: high_q <= cfg_data;
				default:  ;
			endcase
		end
	end

	// Input register
	logic                valid_s1;
	logic [SAMPLE_W-1:0] sample_s1;
	logic                first_s1;
	logic                last_s1;
	logic                room;
	logic                fire;

	assign fire        = valid_s1 && room;
	assign in_ch.ready = !valid_s1 || fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ch.ready) begin
			valid_s1 <= in_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ch.valid && in_ch.ready) begin
			sample_s1 <= in_ch.sample;
			first_s1  <= in_ch.first_sample;
			last_s1   <= in_ch.last_sample;
		end
	end

	// Event state
	logic [IDX_W-1:0]    idx_q;
	logic                seen_q;
	logic [IDX_W-1:0]    first_idx_q;
	logic                run_pend_q;
	logic [RUN_W-1:0]    run_cnt_q;
	logic [WCOUNT_W-1:0] words_q;

	// State as seen by this item, after an optional clear on the first sample
	logic [IDX_W-1:0]    idx_e;
	logic                seen_e;
	logic [IDX_W-1:0]    first_idx_e;
	logic                run_pend_e;
	logic [RUN_W-1:0]    run_cnt_e;
	logic [WCOUNT_W-1:0] words_e;

	logic                kept;
	logic                skip_emit;
	logic [IDX_W-1:0]    idx_n;
	logic                seen_n;
	logic [IDX_W-1:0]    first_idx_n;
	logic                run_pend_n;
	logic [RUN_W-1:0]    run_cnt_n;
	logic [WCOUNT_W-1:0] words_n;

	assign idx_e       = first_s1 ? '0 : idx_q;
	assign seen_e      = seen_q && !first_s1;
	assign first_idx_e = first_s1 ? '0 : first_idx_q;
	assign run_pend_e  = run_pend_q && !first_s1;
	assign run_cnt_e   = first_s1 ? '0 : run_cnt_q;
	assign words_e     = first_s1 ? '0 : words_q;

	// An inverted window keeps every sample through the same two compares.
	assign kept      = (sample_s1 < low_q) || (sample_s1 > high_q);
	assign skip_emit = kept && run_pend_e;

	always_comb begin
		idx_n       = (idx_e == IDX_LAST) ? idx_e : IDX_W'(idx_e + IDX_W'(1));
		seen_n      = seen_e || kept;
		first_idx_n = (kept && !seen_e) ? idx_e : first_idx_e;
		run_pend_n  = run_pend_e;
		run_cnt_n   = run_cnt_e;
		words_n     = words_e;
		if (skip_emit) begin
			words_n = words_inc(words_n);
		end
		if (kept) begin
			words_n    = words_inc(words_n);
			run_pend_n = 1'b0;
			run_cnt_n  = '0;
		end else if (seen_e) begin
			if (run_pend_e) begin
				run_cnt_n = run_cnt_e + RUN_W'(1);
			end else begin
				run_pend_n = 1'b1;
				run_cnt_n  = '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			seen_q      <= 1'b0;
			first_idx_q <= '0;
			run_pend_q  <= 1'b0;
			run_cnt_q   <= '0;
			words_q     <= '0;
		end else if (fire) begin
			if (last_s1) begin
				// A summary always closes the event, first mark or not.
				idx_q       <= '0;
				seen_q      <= 1'b0;
				first_idx_q <= '0;
				run_pend_q  <= 1'b0;
				run_cnt_q   <= '0;
				words_q     <= '0;
			end else begin
				idx_q       <= idx_n;
				seen_q      <= seen_n;
				first_idx_q <= first_idx_n;
				run_pend_q  <= run_pend_n;
				run_cnt_q   <= run_cnt_n;
				words_q     <= words_n;
			end
		end
	end

	// Results of this item, packed in order: skip token, kept sample, summary.
	res_t       slot [MAX_RES];
	res_t       r_skip;
	res_t       r_kept;
	res_t       r_sum;
	logic [1:0] n_res;
	logic [1:0] push_n;

	always_comb begin
		r_skip      = '0;
		r_skip.kind = KIND_SKIP;
		r_skip.word = SKIP_FLAG | SAMPLE_W'(run_cnt_e);

		r_kept      = '0;
		r_kept.kind = KIND_SAMPLE;
		r_kept.word = sample_s1;

		r_sum              = '0;
		r_sum.kind         = KIND_SUMMARY;
		r_sum.first_offset = seen_n ? OFFSET_W'(first_idx_n) : '0;
		r_sum.found        = seen_n;
		r_sum.word_count   = words_n;

		for (int i = 0; i < MAX_RES; i++) begin
			slot[i] = '0;
		end
		n_res = '0;
		if (skip_emit) begin
			slot[n_res] = r_skip;
			n_res       = n_res + 2'd1;
		end
		if (kept) begin
			slot[n_res] = r_kept;
			n_res       = n_res + 2'd1;
		end
		if (last_s1) begin
			slot[n_res] = r_sum;
			n_res       = n_res + 2'd1;
		end
		if (n_res != '0) begin
			slot[n_res - 2'd1].run_end = 1'b1;
		end
	end

	assign push_n = fire ? n_res : '0;

	wzs_res_fifo #(
		.DEPTH    (RES_DEPTH_DEF),
		.PUSH_MAX (MAX_RES)
	) u_res_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push_n    (push_n),
		.push_data (slot),
		.room      (room),
		.out_ch    (out_ch)
	);

	`WZS_ASSERT(a_s1_hold, clk, arst_n, valid_s1 && !fire |=> valid_s1 && $stable(sample_s1))
	`WZS_ASSERT(a_sum_clears, clk, arst_n, fire && last_s1 |=> !seen_q && words_q == '0 && !run_pend_q)
	`WZS_ASSERT(a_skip_after_kept, clk, arst_n, fire && skip_emit |-> seen_e && kept)
	`WZS_NEVER(a_run_unseen, clk, arst_n, run_pend_q && !seen_q)

endmodule
